@@ rtl/core/f2te_pkg.sv @@
package f2te_pkg;

    // Target element format codes.
    typedef enum logic [2:0] {
        FMT_FP32  = 3'd0,
        FMT_FP16  = 3'd1,
        FMT_BF16  = 3'd2,
        FMT_INT8  = 3'd3,
        FMT_UINT8 = 3'd4,
        FMT_INT32 = 3'd5,
        FMT_INT64 = 3'd6,
        FMT_RSVD  = 3'd7
    } t_fmt;

    localparam logic [15:0] HALF_INF = 16'h7c00;
    localparam logic [12:0] HALF_RND = 13'h1000;

    // Decoded input, carried from the decode stage to the shift stage.
    typedef struct packed {
        logic [31:0] bits;
        logic        sign;
        logic        nan;
        logic [7:0]  expo;
        logic [23:0] mant;
        logic        last;
        t_fmt        fmt;
    } t_dec;

    // Integer magnitude and half result, carried to the output stage.
    typedef struct packed {
        logic [31:0] bits;
        logic        sign;
        logic        nan;
        logic        huge;
        logic [63:0] mag;
        logic [15:0] half;
        logic        last;
        t_fmt        fmt;
    } t_mag;

endpackage

@@ rtl/core/fp32_to_tensor_element_convert.sv @@
// Float32 to tensor element converter.
// Input stream (s_axis): one float32 bit pattern per beat in tdata, tlast marks
// the final element of a tensor. Output stream (m_axis): the converted element
// in the low bits of a 64-bit tdata, with tuser carrying the range flag for
// int32/int64 targets, and tlast copied from the input beat.
// The user must write the target format through i_cfg_we/i_cfg_wdata only while
// the block is idle; the block does not enforce this. The format is sampled
// with each beat as it enters the pipeline. Each beat passes through three
// pipeline registers: decode, round/shift, and saturate/select. One beat is
// accepted every cycle unless the output stalls; the rate is set by the
// three-stage pipeline with a single shared enable. When the receiver stalls,
// the whole pipeline holds; s_axis_tready is high whenever the output register
// is empty or being taken, so no beat is lost. Synchronous active-low reset
// clears all valid bits and sets the format to fp32.
module fp32_to_tensor_element_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value_bits
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // result_bits
    output logic        m_axis_tuser,   // out_of_range
    output logic        m_axis_tlast
);
    import f2te_pkg::*;

    t_fmt r_fmt;
    logic en;
    logic v1, v2;
    t_dec dec;
    t_mag mag;

    // Format register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_FP32;
        end else if (i_cfg_we) begin
            r_fmt <= t_fmt'(i_cfg_wdata);
        end
    end

    // Pipeline advances unless the output beat is stalled.
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    f2te_decode u_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid), .i_bits(s_axis_tdata), .i_last(s_axis_tlast),
        .i_fmt(r_fmt), .o_valid(v1), .o_dec(dec)
    );

    f2te_shift u_shf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(v1), .i_dec(dec), .o_valid(v2), .o_mag(mag)
    );

    f2te_pack u_pck (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(v2), .i_mag(mag), .o_valid(m_axis_tvalid),
        .o_res(m_axis_tdata), .o_flag(m_axis_tuser), .o_last(m_axis_tlast)
    );

    // A stalled output beat holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");

    // The flag is only raised for wide integer targets.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:32] == 32'd0
            || m_axis_tdata[63] || m_axis_tdata[62:0] == 63'h7fff_ffff_ffff_ffff)
        else $error("range flag with impossible result");

    // Input is refused only while the output is stalled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused without stall");
endmodule

@@ rtl/core/f2te_decode.sv @@
module f2te_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [31:0]     i_bits,
    input  logic            i_last,
    input  f2te_pkg::t_fmt  i_fmt,
    output logic            o_valid,
    output f2te_pkg::t_dec  o_dec
);
    import f2te_pkg::*;

    logic r_valid;
    t_dec r_dec;
    t_dec n_dec;

    // Split the float into fields and flag NaN.
    always_comb begin
        n_dec.bits = i_bits;
        n_dec.sign = i_bits[31];
        n_dec.expo = i_bits[30:23];
        n_dec.mant = {1'b1, i_bits[22:0]};
        n_dec.nan  = (i_bits[30:23] == 8'hff) && (i_bits[22:0] != 23'd0);
        n_dec.last = i_last;
        n_dec.fmt  = i_fmt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
endmodule

@@ rtl/core/f2te_shift.sv @@
module f2te_shift (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  f2te_pkg::t_dec  i_dec,
    output logic            o_valid,
    output f2te_pkg::t_mag  o_mag
);
    import f2te_pkg::*;

    logic r_valid;
    t_mag r_mag;
    t_mag n_mag;
    logic [7:0]  sh;
    logic [64:0] rnd;
    logic signed [9:0] hex;
    logic [23:0] hm;
    logic [4:0]  hsh;

    // Round the magnitude half away from zero and form the half result.
    always_comb begin
        n_mag.bits = i_dec.bits;
        n_mag.sign = i_dec.sign;
        n_mag.nan  = i_dec.nan;
        n_mag.last = i_dec.last;
        n_mag.fmt  = i_dec.fmt;
        n_mag.huge = i_dec.expo > 8'd190;
        sh  = 8'd0;
        rnd = 65'd0;
        if (i_dec.expo > 8'd190 || i_dec.expo < 8'd126) begin
            n_mag.mag = 64'd0;
        end else if (i_dec.expo >= 8'd150) begin
            sh = i_dec.expo - 8'd150;
            n_mag.mag = {40'd0, i_dec.mant} << sh[5:0];
        end else begin
            sh  = 8'd150 - i_dec.expo;
            rnd = {41'd0, i_dec.mant} + (65'd1 << (sh[4:0] - 5'd1));
            n_mag.mag = rnd[63:0] >> sh[4:0];
        end
        hex = {2'b00, i_dec.expo} - 10'sd112;
        hm  = {1'b0, i_dec.bits[22:0]};
        hsh = 5'd0;
        if (hex <= 0) begin
            if (hex < -10) begin
                n_mag.half = {i_dec.sign, 15'd0};
            end else begin
                hsh = 5'(10'sd1 - hex);
                hm  = i_dec.mant >> hsh;
                n_mag.half = {i_dec.sign, 15'd0} | {5'd0, hm[23:13]};
            end
        end else if (hex >= 31) begin
            n_mag.half = {i_dec.sign, 15'd0} | HALF_INF;
        end else begin
            hm = {1'b0, i_dec.bits[22:0]} + {11'd0, HALF_RND};
            n_mag.half = {i_dec.sign, 15'd0} + ({1'b0, hex[4:0], 10'd0} + {5'd0, hm[23:13]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
        end
    end

    assign o_valid = r_valid;
    assign o_mag   = r_mag;
endmodule

@@ rtl/core/f2te_pack.sv @@
module f2te_pack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  f2te_pkg::t_mag  i_mag,
    output logic            o_valid,
    output logic [63:0]     o_res,
    output logic            o_flag,
    output logic            o_last
);
    import f2te_pkg::*;

    logic        r_valid;
    logic [63:0] r_res;
    logic        r_flag;
    logic        r_last;
    logic [63:0] n_res;
    logic        n_flag;
    logic [63:0] neg;

    // Saturate, negate and select by target format.
    always_comb begin
        n_res  = 64'd0;
        n_flag = 1'b0;
        neg    = 64'd0 - i_mag.mag;
        case (i_mag.fmt)
            FMT_FP32: n_res = {32'd0, i_mag.bits};
            FMT_FP16: n_res = {48'd0, i_mag.half};
            FMT_BF16: n_res = {48'd0, i_mag.bits[31:16]};
            FMT_INT8: begin
                if (i_mag.nan) n_res = 64'h7f;
                else if (!i_mag.sign)
                    n_res = (i_mag.huge || i_mag.mag > 64'd127) ? 64'h7f : i_mag.mag;
                else if (i_mag.huge || i_mag.mag > 64'd128) n_res = 64'h80;
                else n_res = {56'd0, neg[7:0]};
            end
            FMT_UINT8: begin
                if (i_mag.nan) n_res = 64'hff;
                else if (i_mag.sign) n_res = 64'd0;
                else n_res = (i_mag.huge || i_mag.mag > 64'd255) ? 64'hff : i_mag.mag;
            end
            FMT_INT32: begin
                if (i_mag.nan) n_flag = 1'b1;
                else if (!i_mag.sign) begin
                    if (i_mag.huge || i_mag.mag > 64'h7fff_ffff) begin
                        n_flag = 1'b1;
                        n_res  = 64'h7fff_ffff;
                    end else n_res = i_mag.mag;
                end else if (i_mag.huge || i_mag.mag > 64'h8000_0000) begin
                    n_flag = 1'b1;
                    n_res  = 64'h8000_0000;
                end else n_res = {32'd0, neg[31:0]};
            end
            FMT_INT64: begin
                if (i_mag.nan) n_flag = 1'b1;
                else if (!i_mag.sign) begin
                    if (i_mag.huge || i_mag.mag[63]) begin
                        n_flag = 1'b1;
                        n_res  = 64'h7fff_ffff_ffff_ffff;
                    end else n_res = i_mag.mag;
                end else if (i_mag.huge || i_mag.mag > 64'h8000_0000_0000_0000) begin
                    n_flag = 1'b1;
                    n_res  = 64'h8000_0000_0000_0000;
                end else n_res = neg;
            end
            default: n_res = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res  <= n_res;
            r_flag <= n_flag;
            r_last <= i_mag.last;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_flag  = r_flag;
    assign o_last  = r_last;
endmodule
